// ===== src/stn_pkg.sv =====
// Shared types, constants and helper functions for the surface tangent and
// unit normal core. No dependencies; imported by the top level and stn_root_div.
package stn_pkg;

   localparam int ACC_W   = 64;
   localparam int TAN_W   = 32;
   localparam int NRM_W   = 18;
   localparam int DIV_NUM_W = 48;
   localparam int DIV_Q_W = 18;
   localparam logic [NRM_W-1:0] NRM_ONE = 18'd65536;

   // Operation of the shared root / divide unit
   typedef enum logic {
      RD_SQRT,
      RD_DIV
   } rd_mode_type;

   typedef struct packed {
      logic        start;
      rd_mode_type mode;
   } rd_cmd_type;

   // Operand order for the six cross-product multiplies:
   // c0 = u1*v2 - u2*v1, c1 = u2*v0 - u0*v2, c2 = u0*v1 - u1*v0
   localparam logic [1:0] CROSS_U_SEL [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
   localparam logic [1:0] CROSS_V_SEL [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

   // 64-bit signed add, clipped at the signed limits
   function automatic logic signed [ACC_W-1:0] sat_add64(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_add64 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sat_add64 = s[ACC_W-1:0];
      end
   endfunction

   // Q.32 sum to Q16.16: round half up, then clip to 32 bits
   function automatic logic signed [TAN_W-1:0] tangent_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [48:0] t;
      t = $signed({acc[ACC_W-1], acc[ACC_W-1:16]}) + $signed({48'd0, acc[15]});
      if (t > 49'sd2147483647) begin
         tangent_sat = 32'h7FFF_FFFF;
      end else if (t < -49'sd2147483648) begin
         tangent_sat = 32'h8000_0000;
      end else begin
         tangent_sat = t[TAN_W-1:0];
      end
   endfunction

endpackage

// ===== src/surface_tangents_and_unit_normal_core.sv =====
// Top level: sequencer, accumulators and result register of the surface
// tangent and unit normal core. Uses stn_pkg, stn_mul and stn_root_div.
//
//   channel | dir | handshake             | contents
//   req     | in  | req_tvalid/req_tready | point coords, derivatives; tlast = last point
//   rsp     | out | rsp_tvalid/rsp_tready | tangents, unit normal; tuser = degenerate
//
// Each point issues six products through the one shared multiplier.
// The last point of a patch adds the cross product, a shift normalization,
// squares, a 32-step root and three 18-step divides.
// Synchronous active-high reset clears the sums. A new request is taken while
// a result waits; a patch end stalls only until the result register is free.
module surface_tangents_and_unit_normal_core
   import stn_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int DERIV_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // coord_x, coord_y, coord_z, deriv_u, deriv_v (low to high), zero padded
   input  logic [((3*COORD_WIDTH+2*DERIV_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tan_u_x, tan_u_y, tan_u_z, tan_v_x, tan_v_y, tan_v_z,
   // normal_x, normal_y, normal_z (low to high), zero padded
   output logic [247:0] rsp_tdata,
   // degenerate
   output logic rsp_tuser
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = DERIV_WIDTH;
   localparam int MA = (CW > 32) ? CW : 32;
   localparam int MB = (DW > 32) ? DW : 32;
   localparam int PW = MA + MB;

   typedef enum logic [3:0] {
      S_IDLE, S_MAC, S_TAN, S_CROSS, S_MAG, S_NORM, S_SQ, S_ROOT, S_DIV, S_OUT
   } state_type;

   state_type state_ff;
   logic [2:0] step_ff;
   logic [1:0] comp_ff;

   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic signed [DW-1:0] du_ff, dv_ff;
   logic last_ff;

   logic signed [ACC_W-1:0] acc_ff [6];
   logic signed [TAN_W-1:0] tan_u_ff [3];
   logic signed [TAN_W-1:0] tan_v_ff [3];
   logic signed [ACC_W:0]   cross_ff [3];
   logic [ACC_W-1:0]        m_ff [3];
   logic [ACC_W-1:0]        sum_ff;
   logic [31:0]             root_ff;
   logic signed [NRM_W-1:0] nrm_ff [3];
   logic                    degen_ff;

   logic rsp_tvalid_ff;
   logic [247:0] rsp_tdata_ff;
   logic rsp_tuser_ff;

   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;
   logic signed [PW-1:0] prod;
   logic signed [ACC_W-1:0] prod_sat;

   rd_cmd_type  rd_cmd;
   logic [63:0] rd_operand;
   logic        rd_done;
   logic [31:0] rd_result;

   logic [2:0]  j_idx;
   logic [2:0]  pj;
   logic [1:0]  sq_idx;
   logic [ACC_W-1:0] m_or;
   logic [DIV_NUM_W-1:0] num;
   logic [DIV_Q_W-1:0]   q_clip;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   stn_mul #(.A_W(MA), .B_W(MB)) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   stn_root_div u_root_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rd_cmd),
      .operand   (rd_operand),
      .divisor   (root_ff),
      .done_ff   (rd_done),
      .result_ff (rd_result)
   );

   // clip the product to 64 bits
   generate
      if (PW > ACC_W) begin : g_clip
         logic [PW-ACC_W:0] hi;
         assign hi = prod[PW-1:ACC_W-1];
         assign prod_sat = ((&hi) || !(|hi)) ? prod[ACC_W-1:0] :
                           (prod[PW-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}});
      end else begin : g_noclip
         assign prod_sat = prod[ACC_W-1:0];
      end
   endgenerate

   // operand selection for the shared multiplier
   always_comb begin
      j_idx  = (step_ff > 3'd5) ? 3'd0 : step_ff;
      pj     = step_ff - 3'd1;
      sq_idx = (step_ff > 3'd2) ? 2'd0 : step_ff[1:0];
      m_or   = m_ff[0] | m_ff[1] | m_ff[2];
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_MAC: begin
            case (step_ff)
               3'd0, 3'd3: mul_a = MA'(x_ff);
               3'd1, 3'd4: mul_a = MA'(y_ff);
               default:    mul_a = MA'(z_ff);
            endcase
            mul_b = (step_ff < 3'd3) ? MB'(du_ff) : MB'(dv_ff);
         end
         S_CROSS: begin
            mul_a = MA'(tan_u_ff[CROSS_U_SEL[j_idx]]);
            mul_b = MB'(tan_v_ff[CROSS_V_SEL[j_idx]]);
         end
         S_SQ: begin
            mul_a = MA'($signed({1'b0, m_ff[sq_idx][30:0]}));
            mul_b = MB'($signed({1'b0, m_ff[sq_idx][30:0]}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // root / divide command and operand
   always_comb begin
      num        = {1'b0, m_ff[comp_ff][30:0], 16'd0} + {17'd0, root_ff[31:1]};
      rd_cmd     = '{start: 1'b0, mode: RD_SQRT};
      rd_operand = sum_ff;
      if (state_ff == S_ROOT && step_ff == 3'd0) begin
         rd_cmd = '{start: 1'b1, mode: RD_SQRT};
      end else if (state_ff == S_DIV && step_ff == 3'd0) begin
         rd_cmd     = '{start: 1'b1, mode: RD_DIV};
         rd_operand = {16'd0, num};
      end
      q_clip = (rd_result[DIV_Q_W-1:0] > NRM_ONE) ? NRM_ONE : rd_result[DIV_Q_W-1:0];
   end

   // sequencer, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         comp_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
         degen_ff      <= 1'b0;
         for (int i = 0; i < 6; i++) acc_ff[i] <= '0;
      end else begin
         // S_OUT reloads the result register itself
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_OUT) rsp_tvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  x_ff     <= req_tdata[CW-1:0];
                  y_ff     <= req_tdata[2*CW-1:CW];
                  z_ff     <= req_tdata[3*CW-1:2*CW];
                  du_ff    <= req_tdata[3*CW+DW-1:3*CW];
                  dv_ff    <= req_tdata[3*CW+2*DW-1:3*CW+DW];
                  last_ff  <= req_tlast;
                  step_ff  <= '0;
                  state_ff <= S_MAC;
               end
            end
            // issue six products; each lands in the cycle after it is issued
            S_MAC: begin
               if (step_ff != 3'd0) acc_ff[pj] <= sat_add64(acc_ff[pj], prod_sat);
               if (step_ff == 3'd6) begin
                  step_ff  <= '0;
                  state_ff <= last_ff ? S_TAN : S_IDLE;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            // round tangents, clear sums for the next patch
            S_TAN: begin
               for (int i = 0; i < 3; i++) begin
                  tan_u_ff[i] <= tangent_sat(acc_ff[i]);
                  tan_v_ff[i] <= tangent_sat(acc_ff[i+3]);
                  cross_ff[i] <= '0;
                  nrm_ff[i]   <= '0;
               end
               for (int i = 0; i < 6; i++) acc_ff[i] <= '0;
               degen_ff <= 1'b0;
               step_ff  <= '0;
               state_ff <= S_CROSS;
            end
            S_CROSS: begin
               if (step_ff != 3'd0) begin
                  if (pj[0]) cross_ff[pj[2:1]] <= cross_ff[pj[2:1]] - 65'(prod_sat);
                  else       cross_ff[pj[2:1]] <= cross_ff[pj[2:1]] + 65'(prod_sat);
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd6) state_ff <= S_MAG;
            end
            S_MAG: begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i] <= cross_ff[i][ACC_W] ? 64'(-cross_ff[i]) : cross_ff[i][ACC_W-1:0];
               end
               state_ff <= S_NORM;
            end
            // bring largest magnitude to exactly 31 bits, one shift a cycle; all-zero: degenerate
            S_NORM: begin
               if (m_or == '0) begin
                  degen_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else if (m_or[ACC_W-1:31] != '0) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
               end else if (!m_or[30]) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
               end else begin
                  sum_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (step_ff != 3'd0) sum_ff <= sum_ff + prod_sat[ACC_W-1:0];
               if (step_ff == 3'd3) begin
                  step_ff  <= '0;
                  state_ff <= S_ROOT;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            S_ROOT: begin
               if (step_ff == 3'd0) step_ff <= 3'd1;
               else if (rd_done) begin
                  root_ff  <= rd_result;
                  step_ff  <= '0;
                  comp_ff  <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (step_ff == 3'd0) step_ff <= 3'd1;
               else if (rd_done) begin
                  nrm_ff[comp_ff] <= cross_ff[comp_ff][ACC_W] ? -$signed(q_clip)
                                                              : $signed(q_clip);
                  step_ff <= '0;
                  comp_ff <= comp_ff + 2'd1;
                  if (comp_ff == 2'd2) state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {2'b00, nrm_ff[2], nrm_ff[1], nrm_ff[0],
                                    tan_v_ff[2], tan_v_ff[1], tan_v_ff[0],
                                    tan_u_ff[2], tan_u_ff[1], tan_u_ff[0]};
                  rsp_tuser_ff  <= degen_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== src/stn_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on nothing; used by the top level for all products.
module stn_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic                     clock,
   input  logic signed [A_W-1:0]    mul_a,
   input  logic signed [B_W-1:0]    mul_b,
   output logic signed [A_W+B_W-1:0] prod_ff
);

   // one product per cycle, product registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

// ===== src/stn_root_div.sv =====
// Iterative square root (two radicand bits per step) and restoring divider
// (one quotient bit per step) sharing one subtractor. Uses stn_pkg.
module stn_root_div
   import stn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  rd_cmd_type  cmd,
   input  logic [63:0] operand,   // radicand, or dividend in bits 47:0
   input  logic [31:0] divisor,
   output logic        done_ff,
   output logic [31:0] result_ff
);

   logic        busy_ff;
   rd_mode_type mode_ff;
   logic [5:0]  cnt_ff;
   logic [34:0] rem_ff;
   logic [63:0] rad_ff;
   logic [31:0] div_ff;
   logic [34:0] cur;
   logic [34:0] trial;
   logic [35:0] diff;
   logic        ge;

   // shared compare/subtract
   always_comb begin
      if (mode_ff == RD_SQRT) begin
         cur   = {rem_ff[32:0], rad_ff[63:62]};
         trial = {1'b0, result_ff, 2'b01};
      end else begin
         cur   = {rem_ff[33:0], rad_ff[63]};
         trial = {3'b000, div_ff};
      end
      diff = {1'b0, cur} - {1'b0, trial};
      ge   = ~diff[35];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mode_ff <= RD_SQRT;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff   <= 1'b1;
            mode_ff   <= cmd.mode;
            result_ff <= '0;
            div_ff    <= divisor;
            if (cmd.mode == RD_SQRT) begin
               cnt_ff <= 6'd32;
               rem_ff <= '0;
               rad_ff <= operand;
            end else begin
               cnt_ff <= 6'(DIV_Q_W);
               rem_ff <= {5'd0, operand[DIV_NUM_W-1:DIV_Q_W]};
               rad_ff <= {operand[DIV_Q_W-1:0], 46'd0};
            end
         end else if (busy_ff) begin
            rem_ff    <= ge ? diff[34:0] : cur;
            result_ff <= {result_ff[30:0], ge};
            rad_ff    <= (mode_ff == RD_SQRT) ? {rad_ff[61:0], 2'b00} : {rad_ff[62:0], 1'b0};
            cnt_ff    <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule
